// ----- rtl/rvde_pkg.sv -----
`default_nettype none
package rvde_pkg;

   localparam int IMEM_BYTES = 4096;
   localparam int DMEM_BYTES = 4096;
   localparam int IMEM_AW = $clog2(IMEM_BYTES);
   localparam int DMEM_AW = $clog2(DMEM_BYTES);
   localparam int IMEM_WAW = IMEM_AW - 2;
   localparam int DMEM_WAW = DMEM_AW - 2;
   localparam int IMEM_WORDS = IMEM_BYTES / 4;
   localparam int DMEM_WORDS = DMEM_BYTES / 4;
   localparam int CLR_WAW = (IMEM_WAW > DMEM_WAW) ? IMEM_WAW : DMEM_WAW;

   localparam logic [3:0] REGION_IMEM = 4'h0;
   localparam logic [3:0] REGION_DMEM = 4'h1;

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_FENCE  = 7'h0f;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef enum logic [3:0] {
      K_LUI, K_AUIPC, K_JAL, K_JALR, K_BRANCH, K_LOAD, K_STORE, K_ALU, K_NOP, K_ILLEGAL
   } kind_type;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
   } alu_op_type;

   typedef enum logic [1:0] {ST_READ, ST_EXEC, ST_LOAD} state_type;

   typedef struct packed {
      kind_type   kind;
      alu_op_type alu_op;
      logic       use_imm;
      logic [2:0] funct3;
      logic [4:0] rd;
      logic [4:0] rs1;
      logic [4:0] rs2;
      logic [31:0] imm;
   } decoded_type;

   typedef struct packed {
      logic        ren;
      logic [4:0]  raddr1;
      logic [4:0]  raddr2;
      logic        we;
      logic [4:0]  waddr;
      logic [31:0] wdata;
   } rf_req_type;

   typedef struct packed {
      logic        ren;
      logic        wen;
      logic [31:0] addr;
      logic [1:0]  size;
      logic [31:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic [31:0] instr_pc;
      logic [31:0] next_pc;
      logic        rd_write;
      logic [4:0]  rd_index;
      logic [31:0] rd_value;
      logic        store_valid;
      logic [31:0] store_address;
      logic [31:0] store_data;
      logic [1:0]  store_size;
      logic        illegal;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/rv32i_decode_execute.sv -----
// A transaction is decoded on acceptance and queued; the back end reads the register file,
// executes, and for a load that hits a region reads the byte memories (all reads registered),
// then registers the result once the previous one has been popped. It takes the next
// instruction only after the last one is done (register read, then execute, then load).
// Reset: registers and pc read as zero; both memories are cleared by a pass over
// max(IMEM_BYTES, DMEM_BYTES)/4 word addresses, during which req_full stays high.
`default_nettype none
module rv32i_decode_execute
   import rvde_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [31:0] req_instruction,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_instr_pc,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_rd_write,
   output logic [4:0]       rsp_rd_index,
   output logic [31:0]      rsp_rd_value,
   output logic             rsp_store_valid,
   output logic [31:0]      rsp_store_address,
   output logic [31:0]      rsp_store_data,
   output logic [1:0]       rsp_store_size,
   output logic             rsp_illegal,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);

   logic        item_empty, item_pop, mem_busy, rsp_valid;
   decoded_type item;
   rf_req_type  rf_req;
   mem_req_type mem_req;
   logic [31:0] rf_rdata1, rf_rdata2, mem_rdata;
   result_type  rsp;

   rvde_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .instruction (req_instruction),
      .hold        (mem_busy),
      .full        (req_full),
      .item_empty  (item_empty),
      .item        (item),
      .item_pop    (item_pop)
   );

   rvde_regfile u_regfile (
      .clock  (clock),
      .reset  (reset),
      .req    (rf_req),
      .rdata1 (rf_rdata1),
      .rdata2 (rf_rdata2)
   );

   rvde_mem u_mem (
      .clock (clock),
      .reset (reset),
      .req   (mem_req),
      .rdata (mem_rdata),
      .busy  (mem_busy)
   );

   rvde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_empty (item_empty),
      .item       (item),
      .item_pop   (item_pop),
      .rf_req     (rf_req),
      .rf_rdata1  (rf_rdata1),
      .rf_rdata2  (rf_rdata2),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata),
      .rsp_pop    (rsp_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_empty         = !rsp_valid;
   assign rsp_instr_pc      = rsp.instr_pc;
   assign rsp_next_pc       = rsp.next_pc;
   assign rsp_rd_write      = rsp.rd_write;
   assign rsp_rd_index      = rsp.rd_index;
   assign rsp_rd_value      = rsp.rd_value;
   assign rsp_store_valid   = rsp.store_valid;
   assign rsp_store_address = rsp.store_address;
   assign rsp_store_data    = rsp.store_data;
   assign rsp_store_size    = rsp.store_size;
   assign rsp_illegal       = rsp.illegal;

endmodule
`default_nettype wire

// ----- rtl/rvde_front.sv -----
`default_nettype none
module rvde_front
   import rvde_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic [31:0] instruction,
   input  wire logic        hold,
   output logic             full,
   output logic             item_empty,
   output decoded_type      item,
   input  wire logic        item_pop
);

   decoded_type q_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  count_ff, count_in;
   decoded_type dec;
   logic        accept;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] immi, imms, immb, immj, immu;

   always_comb begin
      opc  = instruction[6:0];
      f3   = instruction[14:12];
      f7   = instruction[31:25];
      immi = {{20{instruction[31]}}, instruction[31:20]};
      imms = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
      immb = {{19{instruction[31]}}, instruction[31], instruction[7], instruction[30:25],
              instruction[11:8], 1'b0};
      immj = {{11{instruction[31]}}, instruction[31], instruction[19:12], instruction[20],
              instruction[30:21], 1'b0};
      immu = {instruction[31:12], 12'd0};
      dec.kind    = K_ILLEGAL;
      dec.alu_op  = ALU_ADD;
      dec.use_imm = 1'b1;
      dec.funct3  = f3;
      dec.rd      = instruction[11:7];
      dec.rs1     = instruction[19:15];
      dec.rs2     = instruction[24:20];
      dec.imm     = immi;
      unique case (opc)
         OPC_LUI: begin
            dec.kind = K_LUI;
            dec.imm  = immu;
         end
         OPC_AUIPC: begin
            dec.kind = K_AUIPC;
            dec.imm  = immu;
         end
         OPC_JAL: begin
            dec.kind = K_JAL;
            dec.imm  = immj;
         end
         OPC_JALR: begin
            dec.kind = (f3 == 3'd0) ? K_JALR : K_ILLEGAL;
         end
         OPC_BRANCH: begin
            dec.kind = (f3 == 3'd2 || f3 == 3'd3) ? K_ILLEGAL : K_BRANCH;
            dec.imm  = immb;
         end
         OPC_LOAD: begin
            dec.kind = (f3 == 3'd3 || f3 > 3'd5) ? K_ILLEGAL : K_LOAD;
         end
         OPC_STORE: begin
            dec.kind = (f3 > 3'd2) ? K_ILLEGAL : K_STORE;
            dec.imm  = imms;
         end
         OPC_OPIMM: begin
            dec.kind = K_ALU;
            unique case (f3)
               F3_ADD:  dec.alu_op = ALU_ADD;
               F3_SLT:  dec.alu_op = ALU_SLT;
               F3_SLTU: dec.alu_op = ALU_SLTU;
               F3_XOR:  dec.alu_op = ALU_XOR;
               F3_OR:   dec.alu_op = ALU_OR;
               F3_AND:  dec.alu_op = ALU_AND;
               F3_SLL: begin
                  dec.alu_op = ALU_SLL;
                  if (f7 != F7_ZERO) dec.kind = K_ILLEGAL;
               end
               default: begin
                  if (f7 == F7_ZERO) dec.alu_op = ALU_SRL;
                  else if (f7 == F7_ALT) dec.alu_op = ALU_SRA;
                  else dec.kind = K_ILLEGAL;
               end
            endcase
         end
         OPC_OP: begin
            dec.kind    = K_ALU;
            dec.use_imm = 1'b0;
            if (f7 == F7_ALT && f3 == F3_ADD) dec.alu_op = ALU_SUB;
            else if (f7 == F7_ALT && f3 == F3_SR) dec.alu_op = ALU_SRA;
            else if (f7 != F7_ZERO) dec.kind = K_ILLEGAL;
            else begin
               unique case (f3)
                  F3_ADD:  dec.alu_op = ALU_ADD;
                  F3_SLL:  dec.alu_op = ALU_SLL;
                  F3_SLT:  dec.alu_op = ALU_SLT;
                  F3_SLTU: dec.alu_op = ALU_SLTU;
                  F3_XOR:  dec.alu_op = ALU_XOR;
                  F3_SR:   dec.alu_op = ALU_SRL;
                  F3_OR:   dec.alu_op = ALU_OR;
                  default: dec.alu_op = ALU_AND;
               endcase
            end
         end
         OPC_FENCE, OPC_SYSTEM: begin
            dec.kind = K_NOP;
         end
         default: begin
            dec.kind = K_ILLEGAL;
         end
      endcase
   end

   assign full       = (count_ff == 2'd2) || hold;
   assign accept     = push && !full;
   assign item_empty = (count_ff == 2'd0);
   assign item       = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ accept;
      rptr_in  = rptr_ff ^ item_pop;
      count_in = count_ff + 2'(accept) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) q_ff[wptr_ff] <= dec;
   end

endmodule
`default_nettype wire

// ----- rtl/rvde_regfile.sv -----
`default_nettype none
module rvde_regfile
   import rvde_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  rf_req_type  req,
   output logic [31:0] rdata1,
   output logic [31:0] rdata2
);

   logic [31:0] mem_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] rd1_ff, rd2_ff;
   logic        rv1_ff, rv2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rv1_ff   <= 1'b0;
         rv2_ff   <= 1'b0;
      end else begin
         if (req.we) valid_ff[req.waddr] <= 1'b1;
         if (req.ren) begin
            rv1_ff <= valid_ff[req.raddr1] && (req.raddr1 != 5'd0);
            rv2_ff <= valid_ff[req.raddr2] && (req.raddr2 != 5'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.we) mem_ff[req.waddr] <= req.wdata;
      if (req.ren) begin
         rd1_ff <= mem_ff[req.raddr1];
         rd2_ff <= mem_ff[req.raddr2];
      end
   end

   assign rdata1 = rv1_ff ? rd1_ff : 32'd0;
   assign rdata2 = rv2_ff ? rd2_ff : 32'd0;

endmodule
`default_nettype wire

// ----- rtl/rvde_mem.sv -----
`default_nettype none
module rvde_mem
   import rvde_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  mem_req_type req,
   output logic [31:0] rdata,
   output logic        busy
);

   logic [CLR_WAW-1:0] clr_ff;
   logic               busy_ff;
   logic               in_i, in_d;
   logic [2:0]         nbytes;
   logic [7:0]         ilane_ff [4];
   logic [7:0]         dlane_ff [4];
   logic               rsel_d_ff;
   logic [1:0]         roff_ff;
   logic [31:0]        word;

   assign busy = busy_ff;
   assign in_i = (req.addr[31:28] == REGION_IMEM);
   assign in_d = (req.addr[31:28] == REGION_DMEM);

   always_comb begin
      unique case (req.size)
         SIZE_BYTE: nbytes = 3'd1;
         SIZE_HALF: nbytes = 3'd2;
         default:   nbytes = 3'd4;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         clr_ff <= clr_ff + CLR_WAW'(1);
         if (clr_ff == {CLR_WAW{1'b1}}) busy_ff <= 1'b0;
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [7:0]          imem_ff [IMEM_WORDS];
      logic [7:0]          dmem_ff [DMEM_WORDS];
      logic [1:0]          k;
      logic                carry;
      logic                en;
      logic [IMEM_WAW-1:0] iword;
      logic [DMEM_WAW-1:0] dword;
      logic [7:0]          wbyte;

      always_comb begin
         k     = 2'(l) - req.addr[1:0];
         carry = (2'(l) < req.addr[1:0]);
         iword = req.addr[IMEM_AW-1:2] + IMEM_WAW'(carry);
         dword = req.addr[DMEM_AW-1:2] + DMEM_WAW'(carry);
         en    = ({1'b0, k} < nbytes);
         wbyte = req.wdata[8*k +: 8];
      end

      always_ff @(posedge clock) begin
         if (busy_ff) begin
            imem_ff[clr_ff[IMEM_WAW-1:0]] <= 8'd0;
            dmem_ff[clr_ff[DMEM_WAW-1:0]] <= 8'd0;
         end else if (req.wen && en) begin
            if (in_i) imem_ff[iword] <= wbyte;
            if (in_d) dmem_ff[dword] <= wbyte;
         end
         if (req.ren && !busy_ff) begin
            ilane_ff[l] <= imem_ff[iword];
            dlane_ff[l] <= dmem_ff[dword];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ren && !busy_ff) begin
         rsel_d_ff <= in_d;
         roff_ff   <= req.addr[1:0];
      end
   end

   always_comb begin
      if (rsel_d_ff) word = {dlane_ff[3], dlane_ff[2], dlane_ff[1], dlane_ff[0]};
      else word = {ilane_ff[3], ilane_ff[2], ilane_ff[1], ilane_ff[0]};
      rdata = (word >> {roff_ff, 3'b000}) | (word << (6'd32 - {1'b0, roff_ff, 3'b000}));
   end

endmodule
`default_nettype wire

// ----- rtl/rvde_back.sv -----
`default_nettype none
module rvde_back
   import rvde_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        item_empty,
   input  decoded_type      item,
   output logic             item_pop,
   output rf_req_type       rf_req,
   input  wire logic [31:0] rf_rdata1,
   input  wire logic [31:0] rf_rdata2,
   output mem_req_type      mem_req,
   input  wire logic [31:0] mem_rdata,
   input  wire logic        rsp_pop,
   output logic             rsp_valid,
   output result_type       rsp
);

   state_type   state_ff, state_in;
   decoded_type cur_ff, cur_in;
   logic [31:0] pc_ff, pc_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   result_type  res;
   logic [31:0] a, b, opb, alu, ea, ldv;
   logic [4:0]  sh;
   logic        taken, ea_ok, free, done, wr;

   always_comb begin
      a   = rf_rdata1;
      b   = rf_rdata2;
      opb = cur_ff.use_imm ? cur_ff.imm : b;
      sh  = opb[4:0];
      ea  = a + cur_ff.imm;
      ea_ok = (ea[31:28] == REGION_IMEM) || (ea[31:28] == REGION_DMEM);
      unique case (cur_ff.alu_op)
         ALU_ADD:  alu = a + opb;
         ALU_SUB:  alu = a - opb;
         ALU_SLL:  alu = a << sh;
         ALU_SLT:  alu = {31'd0, $signed(a) < $signed(opb)};
         ALU_SLTU: alu = {31'd0, a < opb};
         ALU_XOR:  alu = a ^ opb;
         ALU_SRL:  alu = a >> sh;
         ALU_SRA:  alu = 32'($signed(a) >>> sh);
         ALU_OR:   alu = a | opb;
         default:  alu = a & opb;
      endcase
      unique case (cur_ff.funct3)
         F3_BEQ:  taken = (a == b);
         F3_BNE:  taken = (a != b);
         F3_BLT:  taken = $signed(a) < $signed(b);
         F3_BGE:  taken = $signed(a) >= $signed(b);
         F3_BLTU: taken = a < b;
         F3_BGEU: taken = a >= b;
         default: taken = 1'b0;
      endcase
      unique case (cur_ff.funct3)
         F3_LB:   ldv = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
         F3_LH:   ldv = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
         F3_LBU:  ldv = {24'd0, mem_rdata[7:0]};
         F3_LHU:  ldv = {16'd0, mem_rdata[15:0]};
         default: ldv = mem_rdata;
      endcase

      res = '0;
      res.instr_pc = pc_ff;
      res.next_pc  = pc_ff + 32'd4;
      wr = 1'b0;
      unique case (cur_ff.kind)
         K_LUI: begin
            wr = 1'b1;
            res.rd_value = cur_ff.imm;
         end
         K_AUIPC: begin
            wr = 1'b1;
            res.rd_value = pc_ff + cur_ff.imm;
         end
         K_JAL: begin
            wr = 1'b1;
            res.rd_value = pc_ff + 32'd4;
            res.next_pc  = pc_ff + cur_ff.imm;
         end
         K_JALR: begin
            wr = 1'b1;
            res.rd_value = pc_ff + 32'd4;
            res.next_pc  = {ea[31:1], 1'b0};
         end
         K_BRANCH: begin
            if (taken) res.next_pc = pc_ff + cur_ff.imm;
         end
         K_LOAD: begin
            wr = ea_ok;
            res.rd_value = ldv;
         end
         K_STORE: begin
            res.store_valid   = 1'b1;
            res.store_address = ea;
            res.store_size    = cur_ff.funct3[1:0];
            unique case (cur_ff.funct3[1:0])
               SIZE_BYTE: res.store_data = {24'd0, b[7:0]};
               SIZE_HALF: res.store_data = {16'd0, b[15:0]};
               default:   res.store_data = b;
            endcase
         end
         K_ALU: begin
            wr = 1'b1;
            res.rd_value = alu;
         end
         K_ILLEGAL: begin
            res.illegal = 1'b1;
         end
         default: begin
         end
      endcase
      if (wr && cur_ff.rd != 5'd0) begin
         res.rd_write = 1'b1;
         res.rd_index = cur_ff.rd;
      end else begin
         res.rd_value = 32'd0;
      end
   end

   always_comb begin
      free         = !out_valid_ff || rsp_pop;
      state_in     = state_ff;
      cur_in       = cur_ff;
      item_pop     = 1'b0;
      done         = 1'b0;
      rf_req.ren    = 1'b0;
      rf_req.raddr1 = item.rs1;
      rf_req.raddr2 = item.rs2;
      mem_req.ren   = 1'b0;
      mem_req.wen   = 1'b0;
      mem_req.addr  = ea;
      mem_req.size  = cur_ff.funct3[1:0];
      mem_req.wdata = res.store_data;
      unique case (state_ff)
         ST_READ: begin
            if (!item_empty) begin
               item_pop   = 1'b1;
               rf_req.ren = 1'b1;
               cur_in     = item;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cur_ff.kind == K_LOAD && ea_ok) begin
               mem_req.ren = 1'b1;
               state_in    = ST_LOAD;
            end else if (free) begin
               done        = 1'b1;
               mem_req.wen = (cur_ff.kind == K_STORE);
               state_in    = ST_READ;
            end
         end
         default: begin
            if (free) begin
               done     = 1'b1;
               state_in = ST_READ;
            end
         end
      endcase
      rf_req.we    = done && res.rd_write;
      rf_req.waddr = res.rd_index;
      rf_req.wdata = res.rd_value;
      pc_in        = pc_ff;
      if (done) pc_in = res.next_pc;
      if (csr_we) pc_in = csr_wdata;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (done) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READ;
         pc_ff        <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule
`default_nettype wire

// ----- sim/rv32i_decode_execute_tb.sv -----
`timescale 1ns / 100ps
module rv32i_decode_execute_tb;
   import rvde_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_instruction = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_instr_pc;
   logic [31:0] rsp_next_pc;
   logic        rsp_rd_write;
   logic [4:0]  rsp_rd_index;
   logic [31:0] rsp_rd_value;
   logic        rsp_store_valid;
   logic [31:0] rsp_store_address;
   logic [31:0] rsp_store_data;
   logic [1:0]  rsp_store_size;
   logic        rsp_illegal;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   localparam logic [31:0] DATA_BASE = 32'h1000_0000;
   localparam logic [31:0] DATA_END  = 32'h2000_0000;

   logic [31:0] gpr[32];
   logic [31:0] cur_pc;
   logic [7:0]  ibytes[IMEM_BYTES];
   logic [7:0]  dbytes[DMEM_BYTES];

   result_type  pending_results[$];
   int          fail_count = 0;
   int          send_idle_pct = 38;
   int          recv_idle_pct = 75;

   rv32i_decode_execute u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_instruction(req_instruction),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_instr_pc(rsp_instr_pc), .rsp_next_pc(rsp_next_pc),
      .rsp_rd_write(rsp_rd_write), .rsp_rd_index(rsp_rd_index), .rsp_rd_value(rsp_rd_value),
      .rsp_store_valid(rsp_store_valid), .rsp_store_address(rsp_store_address),
      .rsp_store_data(rsp_store_data), .rsp_store_size(rsp_store_size),
      .rsp_illegal(rsp_illegal),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
      return {imm, rd, opc};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] opc);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
   endfunction

   task automatic execute_instr(input logic [31:0] ins, output result_type r);
      logic [6:0]  opc;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a, b, immi, nxt, val, ea, v, sdata;
      logic        wr, st, bad, taken;
      logic [1:0]  ssize;
      logic [11:0] idx;
      int          n;
      opc = ins[6:0];
      rd = ins[11:7];
      f3 = ins[14:12];
      rs1 = ins[19:15];
      rs2 = ins[24:20];
      f7 = ins[31:25];
      a = gpr[rs1];
      b = gpr[rs2];
      immi = {{20{ins[31]}}, ins[31:20]};
      nxt = cur_pc + 32'd4;
      wr = 1'b0;
      st = 1'b0;
      bad = 1'b0;
      val = '0;
      ea = '0;
      sdata = '0;
      ssize = '0;
      case (opc)
         OPC_LUI: begin
            wr = 1'b1;
            val = {ins[31:12], 12'h0};
         end
         OPC_AUIPC: begin
            wr = 1'b1;
            val = cur_pc + {ins[31:12], 12'h0};
         end
         OPC_JAL: begin
            wr = 1'b1;
            val = cur_pc + 32'd4;
            nxt = cur_pc + {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
         end
         OPC_JALR: begin
            if (f3 != 3'd0) bad = 1'b1;
            else begin
               wr = 1'b1;
               val = cur_pc + 32'd4;
               nxt = (a + immi) & 32'hffff_fffe;
            end
         end
         OPC_BRANCH: begin
            taken = 1'b0;
            case (f3)
               F3_BEQ:  taken = (a == b);
               F3_BNE:  taken = (a != b);
               F3_BLT:  taken = ($signed(a) < $signed(b));
               F3_BGE:  taken = ($signed(a) >= $signed(b));
               F3_BLTU: taken = (a < b);
               F3_BGEU: taken = (a >= b);
               default: bad = 1'b1;
            endcase
            if (taken)
               nxt = cur_pc + {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
         end
         OPC_LOAD: begin
            ea = a + immi;
            if (f3 == 3'd3 || f3 > 3'd5) bad = 1'b1;
            else if (ea < DATA_END) begin
               n = (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
               v = '0;
               for (int i = 0; i < n; i++) begin
                  idx = 12'(ea + i);
                  v[8*i +: 8] = (ea < DATA_BASE) ? ibytes[idx] : dbytes[idx];
               end
               if (f3 == F3_LB) v = {{24{v[7]}}, v[7:0]};
               else if (f3 == F3_LH) v = {{16{v[15]}}, v[15:0]};
               wr = 1'b1;
               val = v;
            end
         end
         OPC_STORE: begin
            ea = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
            if (f3 > 3'd2) bad = 1'b1;
            else begin
               n = 1 << f3;
               st = 1'b1;
               ssize = f3[1:0];
               sdata = (n == 4) ? b : (b & ((32'd1 << (8 * n)) - 32'd1));
               for (int i = 0; i < n; i++) begin
                  idx = 12'(ea + i);
                  if (ea < DATA_BASE) ibytes[idx] = sdata[8*i +: 8];
                  else if (ea < DATA_END) dbytes[idx] = sdata[8*i +: 8];
               end
            end
         end
         OPC_OPIMM: begin
            wr = 1'b1;
            case (f3)
               F3_ADD:  val = a + immi;
               F3_SLT:  val = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
               F3_SLTU: val = (a < immi) ? 32'd1 : 32'd0;
               F3_XOR:  val = a ^ immi;
               F3_OR:   val = a | immi;
               F3_AND:  val = a & immi;
               F3_SLL: begin
                  if (f7 != F7_ZERO) bad = 1'b1;
                  else val = a << rs2;
               end
               default: begin
                  if (f7 == F7_ZERO) val = a >> rs2;
                  else if (f7 == F7_ALT) val = $signed(a) >>> rs2;
                  else bad = 1'b1;
               end
            endcase
         end
         OPC_OP: begin
            wr = 1'b1;
            if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
            else if (f7 == F7_ALT && f3 == F3_SR) val = $signed(a) >>> b[4:0];
            else if (f7 != F7_ZERO) bad = 1'b1;
            else begin
               case (f3)
                  F3_ADD:  val = a + b;
                  F3_SLL:  val = a << b[4:0];
                  F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                  F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
                  F3_XOR:  val = a ^ b;
                  F3_SR:   val = a >> b[4:0];
                  F3_OR:   val = a | b;
                  default: val = a & b;
               endcase
            end
         end
         OPC_FENCE, OPC_SYSTEM: ;
         default: bad = 1'b1;
      endcase
      if (bad) begin
         wr = 1'b0;
         st = 1'b0;
         nxt = cur_pc + 32'd4;
      end
      if (wr && rd == 5'd0) wr = 1'b0;
      if (wr) gpr[rd] = val;
      r.instr_pc = cur_pc;
      r.next_pc = nxt;
      r.rd_write = wr;
      r.rd_index = wr ? rd : 5'd0;
      r.rd_value = wr ? val : 32'd0;
      r.store_valid = st;
      r.store_address = st ? ea : 32'd0;
      r.store_data = st ? sdata : 32'd0;
      r.store_size = st ? ssize : 2'd0;
      r.illegal = bad;
      cur_pc = nxt;
   endtask

   task automatic send_instr(input logic [31:0] ins, input bit typed, input result_type typed_exp);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_instruction <= ins;
      do @(posedge clock); while (req_full);
      execute_instr(ins, predicted);
      pending_results.push_back(typed ? typed_exp : predicted);
   endtask

   task automatic drain_and_load_pc(input logic [31:0] value);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_pc = value;
   endtask

   function automatic logic [4:0] pick_rd();
      return ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(31, 4));
   endfunction

   function automatic logic [4:0] pick_base();
      return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3, 1));
   endfunction

   function automatic logic [31:0] random_instr();
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3, ld_f3;
      logic [6:0]  f7;
      logic [11:0] imm;
      int          c;
      rd = pick_rd();
      rs1 = 5'($urandom_range(31));
      rs2 = 5'($urandom_range(31));
      f3 = 3'($urandom);
      f7 = ($urandom_range(9) == 0) ? 7'($urandom) : ($urandom_range(1) ? F7_ALT : F7_ZERO);
      imm = 12'($urandom);
      c = $urandom_range(99);
      case ($urandom_range(4))
         0: ld_f3 = F3_LB;
         1: ld_f3 = F3_LH;
         2: ld_f3 = F3_LW;
         3: ld_f3 = F3_LBU;
         default: ld_f3 = F3_LHU;
      endcase
      if ($urandom_range(7) == 0) ld_f3 = f3;
      if (c < 8) return $urandom;
      if (c < 12) begin
         case ($urandom_range(2))
            0: return enc_u(20'h10000, 5'd1, OPC_LUI);
            1: return enc_u(20'h0, 5'd2, OPC_LUI);
            default: return enc_u($urandom_range(1) ? 20'h20000 : 20'hfffff, 5'd3, OPC_LUI);
         endcase
      end
      if (c < 18) return enc_u(20'($urandom), rd, OPC_LUI);
      if (c < 22) return enc_u(20'($urandom), rd, OPC_AUIPC);
      if (c < 27) return {20'($urandom), rd, OPC_JAL};
      if (c < 31)
         return enc_i(imm, rs1, ($urandom_range(7) == 0) ? f3 : 3'd0, rd, OPC_JALR);
      if (c < 41) return {f7, rs2, rs1, f3, 5'($urandom), OPC_BRANCH};
      if (c < 53) return enc_i(imm, pick_base(), ld_f3, rd, OPC_LOAD);
      if (c < 65)
         return enc_s(imm, rs2, pick_base(),
                      ($urandom_range(7) == 0) ? f3 : 3'($urandom_range(2)));
      if (c < 80)
         return {(f3 == F3_SLL || f3 == F3_SR) ? f7 : imm[11:5], rs2, rs1, f3, rd, OPC_OPIMM};
      if (c < 95) return enc_r(f7, rs2, rs1, f3, rd, OPC_OP);
      return {25'($urandom), $urandom_range(1) ? OPC_FENCE : OPC_SYSTEM};
   endfunction

   always @(posedge clock) begin
      result_type observed, wanted;
      if (!reset && rsp_pop && !rsp_empty) begin
         observed = '{rsp_instr_pc, rsp_next_pc, rsp_rd_write, rsp_rd_index, rsp_rd_value,
                      rsp_store_valid, rsp_store_address, rsp_store_data, rsp_store_size,
                      rsp_illegal};
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected transaction at pc %h", rsp_instr_pc);
         end else begin
            wanted = pending_results.pop_front();
            if (observed !== wanted) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch expected pc %h next %h rd %b/%0d/%h st %b/%h/%h/%0d ill %b",
                           wanted.instr_pc, wanted.next_pc, wanted.rd_write, wanted.rd_index,
                           wanted.rd_value, wanted.store_valid, wanted.store_address,
                           wanted.store_data, wanted.store_size, wanted.illegal);
                  $display("         actual   pc %h next %h rd %b/%0d/%h st %b/%h/%h/%0d ill %b",
                           observed.instr_pc, observed.next_pc, observed.rd_write,
                           observed.rd_index, observed.rd_value, observed.store_valid,
                           observed.store_address, observed.store_data, observed.store_size,
                           observed.illegal);
               end
            end
         end
      end
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [31:0] directed[];
      result_type  typed_rows[2];
      logic [31:0] start_values[6];
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < IMEM_BYTES; i++) ibytes[i] = '0;
      for (int i = 0; i < DMEM_BYTES; i++) dbytes[i] = '0;
      cur_pc = '0;
      directed = '{
         enc_u(20'hfffff, 5'd5, OPC_LUI),
         32'hffff_ffff,
         32'h0000_0000,
         enc_i(12'h001, 5'd5, F3_ADD, 5'd0, OPC_OPIMM),
         enc_u(20'h10000, 5'd1, OPC_LUI),
         enc_u(20'h20000, 5'd3, OPC_LUI),
         enc_i(12'hfff, 5'd0, F3_ADD, 5'd6, OPC_OPIMM),
         enc_s(12'hffe, 5'd6, 5'd1, {1'b0, SIZE_WORD}),
         enc_s(12'h7ff, 5'd6, 5'd1, {1'b0, SIZE_HALF}),
         enc_i(12'h7ff, 5'd1, F3_LBU, 5'd7, OPC_LOAD),
         enc_i(12'h7ff, 5'd1, F3_LB, 5'd8, OPC_LOAD),
         enc_i(12'h7ff, 5'd1, F3_LHU, 5'd9, OPC_LOAD),
         enc_i(12'hffe, 5'd1, F3_LW, 5'd10, OPC_LOAD),
         enc_s(12'h000, 5'd6, 5'd3, {1'b0, SIZE_WORD}),
         enc_i(12'h000, 5'd3, F3_LW, 5'd11, OPC_LOAD),
         enc_i({F7_ALT, 5'd31}, 5'd6, F3_SR, 5'd12, OPC_OPIMM),
         enc_r(F7_ALT, 5'd6, 5'd5, F3_ADD, 5'd13, OPC_OP),
         enc_r(7'h01, 5'd6, 5'd5, F3_ADD, 5'd14, OPC_OP),
         32'hffff_ff8f,
         32'hffff_fff3,
         enc_b(13'h0010, 5'd6, 5'd6, F3_BEQ),
         enc_b(13'h1ff0, 5'd6, 5'd5, F3_BLTU),
         enc_b(13'h0008, 5'd0, 5'd0, 3'd2),
         enc_j(21'h1ffffc, 5'd15),
         enc_i(12'h001, 5'd5, 3'd0, 5'd5, OPC_JALR),
         enc_i(12'h000, 5'd1, 3'd3, 5'd16, OPC_LOAD),
         enc_s(12'h000, 5'd6, 5'd1, 3'd3)
      };
      typed_rows[0] = '{32'h0, 32'h4, 1'b1, 5'd5, 32'hffff_f000, 1'b0, 32'h0, 32'h0, 2'd0,
                        1'b0};
      typed_rows[1] = '{32'h4, 32'h8, 1'b0, 5'd0, 32'h0, 1'b0, 32'h0, 32'h0, 2'd0, 1'b1};
      start_values = '{32'h0000_0000, 32'hffff_ffff, 32'h1000_0000, $urandom,
                       32'hffff_fff0, $urandom};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (req_full);
      drain_and_load_pc(32'h0);

      foreach (directed[i]) send_instr(directed[i], i < 2, typed_rows[i < 2 ? i : 0]);

      for (int phase = 0; phase < 6; phase++) begin
         drain_and_load_pc(start_values[phase]);
         case (phase / 2)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < 88; n++) send_instr(random_instr(), 1'b0, typed_rows[0]);
      end

      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
